// ----- sv/kmf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// kmf_pkg
// Shared types, codes and helpers of the k-way merge with duplicate folding.
// ---------------------------------------------------------------------------
package kmf_pkg;

	localparam int KMF_MAX_LANES = 16;
	localparam int KEY_W         = 256;
	localparam int LANE_W        = 4;
	localparam int LANE_CNT_W    = 7;
	localparam int TIP_W         = 32;

	typedef logic [KEY_W-1:0] key_t;

	typedef enum logic [1:0] {
		ST_AWAIT = 2'd0,
		ST_HOLD  = 2'd1,
		ST_EXH   = 2'd2
	} lane_st_t;

	typedef enum logic {
		REG_LANES = 1'b0,
		REG_TIPS  = 1'b1
	} reg_idx_t;

	typedef enum logic [4:0] {
		S_IDLE    = 5'b00001,
		S_CHECK   = 5'b00010,
		S_SCAN    = 5'b00100,
		S_RESOLVE = 5'b01000,
		S_OUT     = 5'b10000
	} state_t;

	typedef struct packed {
		logic              valid;
		key_t              key;
		logic [1:0]        flags;
		logic [LANE_W-1:0] lane;
	} cand_t;

	typedef struct packed {
		logic       wr_en;
		logic       wr_exh;
		key_t       wr_key;
		logic [1:0] wr_flags;
		logic       clr;
		logic       enable;
	} cell_ctl_t;

	function automatic logic key_less(input key_t a, input key_t b);
		key_less = a < b;
	endfunction

endpackage
`default_nettype wire

// ----- sv/kway_merge_fold_tip_filter.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Timing: a rejected transaction gives its result in the cycle after acceptance; a transaction
// that completes the set of lane heads gives its result after S_CHECK, S_SCAN and S_RESOLVE.
// Other accepted transactions give no result. One transaction is in flight at a time; the
// minimum search walks the chain of MAX_LANES lane cells.
// Reset: asynchronous; all lanes await a record, accumulator and tip count are cleared.
// ---------------------------------------------------------------------------
// kway_merge_fold_tip_filter
// K-way merge of sorted lanes of 256-bit keys with folding of equal keys.
// ---------------------------------------------------------------------------
module kway_merge_fold_tip_filter
	import kmf_pkg::*;
#(
	parameter int MAX_LANES = KMF_MAX_LANES
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                cfg_we,
	input  wire                cfg_index,
	input  wire  [4:0]         cfg_wdata,
	input  wire                in_valid,
	output logic               in_stall,
	input  wire                kind,
	input  wire  [3:0]         lane,
	input  wire  [63:0]        key_w0,
	input  wire  [63:0]        key_w1,
	input  wire  [63:0]        key_w2,
	input  wire  [63:0]        key_w3,
	input  wire                is_node,
	input  wire                is_parent,
	output logic               res_valid,
	input  wire                res_stall,
	output logic               refill_valid,
	output logic [3:0]         refill_lane,
	output logic               out_valid,
	output logic [63:0]        out_w0,
	output logic [63:0]        out_w1,
	output logic [63:0]        out_w2,
	output logic [63:0]        out_w3,
	output logic               out_node,
	output logic               out_parent,
	output logic               done_res,
	output logic               protocol_error,
	output logic [31:0]        tip_count
);

	localparam int CNT_W = $clog2(MAX_LANES + 1);

	state_t                state_q;
	logic [4:0]            lanes_q;
	logic                  tips_q;
	key_t                  acc_key_q;
	logic [1:0]            acc_flags_q;
	logic                  acc_valid_q;
	logic [TIP_W-1:0]      tips_seen_q;
	logic [CNT_W-1:0]      cnt_q;

	logic [LANE_CNT_W-1:0] n_eff;
	lane_st_t              cell_st [MAX_LANES];
	lane_st_t              st16 [16];
	cell_ctl_t             ctl [MAX_LANES];
	cand_t                 chain [MAX_LANES+1];
	cand_t                 best;
	logic                  accept;
	logic                  lane_bad;
	logic                  any_await;
	logic                  resolve;
	logic                  tip_ok;
	logic                  emit;
	logic                  fold;
	logic [TIP_W-1:0]      tips_next;

	always_comb begin
		n_eff = {2'b00, lanes_q};
		if (n_eff == '0) n_eff = LANE_CNT_W'(1);
		if (n_eff > LANE_CNT_W'(MAX_LANES)) n_eff = LANE_CNT_W'(MAX_LANES);
		if (n_eff > LANE_CNT_W'(16)) n_eff = LANE_CNT_W'(16);
	end

	for (genvar k = 0; k < 16; k++) begin : g_st16
		if (k < MAX_LANES) begin : g_in
			assign st16[k] = cell_st[k];
		end else begin : g_out
			assign st16[k] = ST_EXH;
		end
	end

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign lane_bad = ({3'b000, lane} >= n_eff) || (st16[lane] != ST_AWAIT);
	assign resolve  = (state_q == S_RESOLVE);
	assign best     = chain[MAX_LANES];

	always_comb begin
		any_await = 1'b0;
		for (int i = 0; i < MAX_LANES; i++) begin
			if (LANE_CNT_W'(i) < n_eff && cell_st[i] == ST_AWAIT) any_await = 1'b1;
		end
	end

	assign chain[0] = '0;

	for (genvar i = 0; i < MAX_LANES; i++) begin : g_cell
		always_comb begin
			ctl[i].wr_en    = accept && !lane_bad && (LANE_CNT_W'(i) == {3'b000, lane});
			ctl[i].wr_exh   = kind;
			ctl[i].wr_key   = {key_w3, key_w2, key_w1, key_w0};
			ctl[i].wr_flags = {is_parent, is_node};
			ctl[i].clr      = resolve && (!best.valid ||
				(LANE_CNT_W'(i) == {3'b000, best.lane}));
			ctl[i].enable   = LANE_CNT_W'(i) < n_eff;
		end

		kmf_cell #(
			.LANE_ID(i)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl[i]),
			.cand_in (chain[i]),
			.cand_out(chain[i+1]),
			.status  (cell_st[i])
		);
	end

	always_comb begin
		tip_ok    = acc_flags_q[0] && !acc_flags_q[1];
		emit      = acc_valid_q && (!tips_q || tip_ok);
		tips_next = tips_seen_q;
		if (acc_valid_q && tips_q && tip_ok && tips_seen_q != '1) begin
			tips_next = tips_seen_q + TIP_W'(1);
		end
		fold = best.valid && acc_valid_q && (best.key == acc_key_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lanes_q <= 5'd2;
			tips_q  <= 1'b0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_LANES: lanes_q <= cfg_wdata;
				REG_TIPS:  tips_q  <= cfg_wdata[0];
				default:   lanes_q <= lanes_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			cnt_q          <= '0;
			acc_key_q      <= '0;
			acc_flags_q    <= '0;
			acc_valid_q    <= 1'b0;
			tips_seen_q    <= '0;
			res_valid      <= 1'b0;
			refill_valid   <= 1'b0;
			refill_lane    <= '0;
			out_valid      <= 1'b0;
			out_w0         <= '0;
			out_w1         <= '0;
			out_w2         <= '0;
			out_w3         <= '0;
			out_node       <= 1'b0;
			out_parent     <= 1'b0;
			done_res       <= 1'b0;
			protocol_error <= 1'b0;
			tip_count      <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (lane_bad) begin
							res_valid      <= 1'b1;
							refill_valid   <= 1'b0;
							refill_lane    <= '0;
							out_valid      <= 1'b0;
							out_w0         <= '0;
							out_w1         <= '0;
							out_w2         <= '0;
							out_w3         <= '0;
							out_node       <= 1'b0;
							out_parent     <= 1'b0;
							done_res       <= 1'b0;
							protocol_error <= 1'b1;
							tip_count      <= tips_seen_q;
							state_q        <= S_OUT;
						end else begin
							state_q <= S_CHECK;
						end
					end
				end
				S_CHECK: begin
					cnt_q   <= '0;
					state_q <= any_await ? S_IDLE : S_SCAN;
				end
				S_SCAN: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(MAX_LANES - 1)) state_q <= S_RESOLVE;
				end
				S_RESOLVE: begin
					res_valid      <= 1'b1;
					protocol_error <= 1'b0;
					out_valid      <= 1'b0;
					out_w0         <= '0;
					out_w1         <= '0;
					out_w2         <= '0;
					out_w3         <= '0;
					out_node       <= 1'b0;
					out_parent     <= 1'b0;
					if (!fold && emit) begin
						out_valid  <= 1'b1;
						out_w0     <= acc_key_q[63:0];
						out_w1     <= acc_key_q[127:64];
						out_w2     <= acc_key_q[191:128];
						out_w3     <= acc_key_q[255:192];
						out_node   <= acc_flags_q[0];
						out_parent <= acc_flags_q[1];
					end
					if (!best.valid) begin
						done_res     <= 1'b1;
						refill_valid <= 1'b0;
						refill_lane  <= '0;
						tip_count    <= tips_next;
						acc_key_q    <= '0;
						acc_flags_q  <= '0;
						acc_valid_q  <= 1'b0;
						tips_seen_q  <= '0;
					end else begin
						done_res     <= 1'b0;
						refill_valid <= 1'b1;
						refill_lane  <= best.lane;
						if (fold) begin
							acc_flags_q <= acc_flags_q | best.flags;
							tip_count   <= tips_seen_q;
						end else begin
							acc_key_q   <= best.key;
							acc_flags_q <= best.flags;
							acc_valid_q <= 1'b1;
							tips_seen_q <= tips_next;
							tip_count   <= tips_next;
						end
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!res_stall) begin
						res_valid <= 1'b0;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- sv/kmf_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// kmf_cell
// One lane cell: holds the lane head and status and passes the smaller of
// its own head and the incoming candidate to the next cell.
// ---------------------------------------------------------------------------
module kmf_cell
	import kmf_pkg::*;
#(
	parameter int LANE_ID = 0
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire cell_ctl_t ctl,
	input  wire cand_t  cand_in,
	output cand_t       cand_out,
	output lane_st_t    status
);

	key_t       head_key_q;
	logic [1:0] head_flags_q;
	lane_st_t   status_q;
	cand_t      cand_q;
	cand_t      own;
	cand_t      pick;

	always_ff @(posedge clk) begin
		if (ctl.wr_en && !ctl.wr_exh) begin
			head_key_q   <= ctl.wr_key;
			head_flags_q <= ctl.wr_flags;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q <= ST_AWAIT;
		end else if (ctl.clr) begin
			status_q <= ST_AWAIT;
		end else if (ctl.wr_en) begin
			status_q <= ctl.wr_exh ? ST_EXH : ST_HOLD;
		end
	end

	always_comb begin
		own.valid = 1'b1;
		own.key   = head_key_q;
		own.flags = head_flags_q;
		own.lane  = LANE_W'(LANE_ID);
		if (!(ctl.enable && status_q == ST_HOLD)) begin
			pick = cand_in;
		end else if (!cand_in.valid || key_less(head_key_q, cand_in.key)) begin
			pick = own;
		end else begin
			pick = cand_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_q <= '0;
		end else begin
			cand_q <= pick;
		end
	end

	assign cand_out = cand_q;
	assign status   = status_q;

endmodule
`default_nettype wire

// ----- sv/kmf_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// kmf_checker
// Port-level checks of the merge block, bound to the top level.
// ---------------------------------------------------------------------------
module kmf_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        res_valid,
	input wire        res_stall,
	input wire        refill_valid,
	input wire [3:0]  refill_lane,
	input wire        out_valid,
	input wire [63:0] out_w0,
	input wire        out_node,
	input wire        done_res,
	input wire        protocol_error
);

	a_err_alone: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && protocol_error |-> !out_valid && !refill_valid && !done_res)
		else $error("Error transaction carries other results.");

	a_done_no_refill: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && done_res |-> !refill_valid && refill_lane == 4'd0)
		else $error("Done transaction requests a refill.");

	a_out_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !out_valid |-> out_w0 == 64'd0 && !out_node)
		else $error("Key fields not cleared without an emitted record.");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(refill_lane))
		else $error("Stalled result transaction changed.");

endmodule

bind kway_merge_fold_tip_filter kmf_checker u_kmf_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.res_valid     (res_valid),
	.res_stall     (res_stall),
	.refill_valid  (refill_valid),
	.refill_lane   (refill_lane),
	.out_valid     (out_valid),
	.out_w0        (out_w0),
	.out_node      (out_node),
	.done_res      (done_res),
	.protocol_error(protocol_error)
);
`default_nettype wire

// ----- tb/kway_merge_fold_tip_filter_test.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kway_merge_fold_tip_filter_test
// Drives sorted lanes of keys into the merge block, predicts every result
// transaction from its own model of the merge and compares them field by field.
// ---------------------------------------------------------------------------
module kway_merge_fold_tip_filter_test
	import kmf_pkg::*;
();

	localparam int HEAD_LIMIT  = 30;
	localparam int LONG_HOLD   = 300;
	localparam int STUCK_LIMIT = 3000;

	typedef struct packed {
		logic        refill_valid;
		logic [3:0]  refill_lane;
		logic        out_valid;
		key_t        out_key;
		logic        out_node;
		logic        out_parent;
		logic        done_res;
		logic        protocol_error;
		logic [31:0] tip_count;
	} merge_res_t;

	class merge_scoreboard;
		lane_st_t    lane_st[16];
		key_t        head_key[16];
		logic [1:0]  head_flags[16];
		key_t        acc_key;
		logic [1:0]  acc_flags;
		logic        acc_valid;
		logic [31:0] tips_seen;
		logic [4:0]  lanes_reg;
		logic        tips_only;
		logic        merge_done;
		merge_res_t  pending[$];
		int          mismatches;

		function void rearm();
			foreach (lane_st[i]) lane_st[i] = ST_AWAIT;
			acc_key   = '0;
			acc_flags = '0;
			acc_valid = 1'b0;
			tips_seen = '0;
		endfunction

		function new();
			rearm();
			lanes_reg  = 5'd2;
			tips_only  = 1'b0;
			merge_done = 1'b0;
			mismatches = 0;
		endfunction

		function int eff_lanes();
			int n;
			n = lanes_reg;
			if (n == 0) n = 1;
			if (n > 16) n = 16;
			return n;
		endfunction

		function void flush(inout merge_res_t r);
			if (!acc_valid) return;
			if (tips_only) begin
				if (!(acc_flags[0] && !acc_flags[1])) return;
				if (tips_seen != 32'hffff_ffff) tips_seen++;
			end
			r.out_valid  = 1'b1;
			r.out_key    = acc_key;
			r.out_node   = acc_flags[0];
			r.out_parent = acc_flags[1];
		endfunction

		function void note_input(logic kind, logic [3:0] lane, key_t key, logic [1:0] fl);
			merge_res_t r;
			int n;
			int best;
			r = '{default: '0};
			n = eff_lanes();
			if (lane >= n || lane_st[lane] != ST_AWAIT) begin
				r.protocol_error = 1'b1;
				r.tip_count = tips_seen;
				pending.insert(pending.size(), r);
				return;
			end
			if (kind) begin
				lane_st[lane] = ST_EXH;
			end else begin
				head_key[lane]   = key;
				head_flags[lane] = fl;
				lane_st[lane]    = ST_HOLD;
			end
			for (int i = 0; i < n; i++)
				if (lane_st[i] == ST_AWAIT) return;
			best = -1;
			for (int i = 0; i < n; i++)
				if (lane_st[i] == ST_HOLD && (best < 0 || head_key[i] < head_key[best]))
					best = i;
			if (best < 0) begin
				flush(r);
				r.done_res  = 1'b1;
				r.tip_count = tips_seen;
				pending.insert(pending.size(), r);
				rearm();
				merge_done = 1'b1;
				return;
			end
			if (acc_valid && head_key[best] == acc_key) begin
				acc_flags |= head_flags[best];
			end else begin
				flush(r);
				acc_key   = head_key[best];
				acc_flags = head_flags[best];
				acc_valid = 1'b1;
			end
			lane_st[best]  = ST_AWAIT;
			r.refill_valid = 1'b1;
			r.refill_lane  = best[3:0];
			r.tip_count    = tips_seen;
			pending.insert(pending.size(), r);
		endfunction

		function void check(merge_res_t act);
			merge_res_t e;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("Unexpected result transaction: %p", act);
				return;
			end
			e = pending.pop_front();
			if (e !== act) begin
				mismatches++;
				if (mismatches <= 10) $display("Mismatch: expected %p, actual %p", e, act);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	reg_idx_t    cfg_index;
	logic [4:0]  cfg_wdata;
	logic        in_valid;
	logic        in_stall;
	logic        kind;
	logic [3:0]  lane;
	logic [63:0] key_w0, key_w1, key_w2, key_w3;
	logic        is_node, is_parent;
	logic        res_valid, res_stall;
	logic        refill_valid;
	logic [3:0]  refill_lane;
	logic        out_valid;
	logic [63:0] out_w0, out_w1, out_w2, out_w3;
	logic        out_node, out_parent, done_res, protocol_error;
	logic [31:0] tip_count;

	merge_scoreboard sb;
	logic idle_on;
	logic hold_req;
	int   stuck;
	int   items;

	kway_merge_fold_tip_filter i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall),
		.kind(kind), .lane(lane),
		.key_w0(key_w0), .key_w1(key_w1), .key_w2(key_w2), .key_w3(key_w3),
		.is_node(is_node), .is_parent(is_parent),
		.res_valid(res_valid), .res_stall(res_stall),
		.refill_valid(refill_valid), .refill_lane(refill_lane),
		.out_valid(out_valid),
		.out_w0(out_w0), .out_w1(out_w1), .out_w2(out_w2), .out_w3(out_w3),
		.out_node(out_node), .out_parent(out_parent),
		.done_res(done_res), .protocol_error(protocol_error), .tip_count(tip_count)
	);

	always #10 clk = ~clk;

	function automatic int gap_len();
		int p;
		if (!idle_on) return 0;
		p = $urandom_range(0, 99);
		if (p < 65) return 0;
		if (p < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic key_t rand_key();
		return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
	endfunction

	task automatic send(logic k, logic [3:0] ln, key_t key, logic [1:0] fl);
		int g;
		in_valid  <= 1'b1;
		kind      <= k;
		lane      <= ln;
		{key_w3, key_w2, key_w1, key_w0} <= key;
		is_node   <= fl[0];
		is_parent <= fl[1];
		do @(posedge clk); while (in_stall);
		sb.note_input(k, ln, key, fl);
		items++;
		g = gap_len();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic wait_quiet();
		in_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (HEAD_LIMIT) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [4:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		if (idx == REG_LANES) sb.lanes_reg = val;
		else sb.tips_only = val[0];
		cfg_we <= 1'b0;
	endtask

	task automatic run_merge(logic long_hold);
		int   n;
		int   left[16];
		key_t cur[16];
		key_t base;
		int   awaiting[$];
		int   cnt;
		int   l;
		base = rand_key();
		if ($urandom_range(0, 9) == 0) base = '0;
		n = sb.eff_lanes();
		for (int i = 0; i < 16; i++) begin
			left[i] = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 5);
			cur[i]  = base + $urandom_range(0, 4);
		end
		sb.merge_done = 1'b0;
		cnt = 0;
		while (!sb.merge_done) begin
			if (long_hold && cnt == 3) hold_req = 1'b1;
			cnt++;
			if ($urandom_range(0, 99) < 6) begin
				send(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)), rand_key(),
					2'($urandom_range(0, 3)));
			end else begin
				awaiting.delete();
				for (int i = 0; i < n; i++)
					if (sb.lane_st[i] == ST_AWAIT) awaiting.insert(awaiting.size(), i);
				l = awaiting[$urandom_range(0, awaiting.size() - 1)];
				if (left[l] == 0) begin
					send(1'b1, 4'(l), rand_key(), 2'($urandom_range(0, 3)));
				end else begin
					send(1'b0, 4'(l), cur[l], 2'($urandom_range(0, 3)));
					cur[l] += $urandom_range(0, 2);
					left[l]--;
				end
			end
		end
	endtask

	always @(posedge clk) begin
		if (res_valid && !res_stall)
			sb.check('{refill_valid, refill_lane, out_valid, {out_w3, out_w2, out_w1, out_w0},
				out_node, out_parent, done_res, protocol_error, tip_count});
		if ((in_valid && !in_stall) || (res_valid && !res_stall) || !arst_n) stuck <= 0;
		else stuck <= stuck + 1;
		if (stuck >= STUCK_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		res_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				res_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (idle_on && $urandom_range(0, 99) < 3) begin
				res_stall <= 1'b1;
				repeat ($urandom_range(5, 30)) @(posedge clk);
			end else begin
				res_stall <= idle_on && ($urandom_range(0, 3) == 0);
			end
		end
	end

	initial begin
		key_t ones;
		logic [4:0] lanes_pick;
		sb = new();
		ones = '1;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_LANES;
		cfg_wdata = '0;
		in_valid = 1'b0;
		kind = 1'b0;
		lane = '0;
		{key_w3, key_w2, key_w1, key_w0} = '0;
		is_node = 1'b0;
		is_parent = 1'b0;
		idle_on = 1'b1;
		hold_req = 1'b0;
		stuck = 0;
		items = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send(1'b0, 4'd5, ones, 2'b11);
		send(1'b0, 4'd0, '0, 2'b01);
		send(1'b0, 4'd1, ones, 2'b10);
		send(1'b0, 4'd1, ones, 2'b01);
		send(1'b0, 4'd0, ones, 2'b01);
		send(1'b1, 4'd0, '0, 2'b00);
		send(1'b1, 4'd1, '0, 2'b00);
		wait_quiet();
		write_reg(REG_TIPS, 5'd1);
		write_reg(REG_LANES, 5'd1);
		send(1'b0, 4'd0, {64'h8000_0000_0000_0000, 192'd7}, 2'b01);
		send(1'b0, 4'd0, {64'h8000_0000_0000_0000, 192'd7}, 2'b10);
		send(1'b0, 4'd0, {64'h8000_0000_0000_0001, 192'd0}, 2'b01);
		send(1'b0, 4'd0, {64'h8000_0000_0000_0002, 192'd0}, 2'b01);
		send(1'b1, 4'd0, '0, 2'b00);
		wait_quiet();
		write_reg(REG_LANES, 5'd0);
		send(1'b0, 4'd1, '0, 2'b00);
		send(1'b1, 4'd0, '0, 2'b00);
		wait_quiet();
		write_reg(REG_LANES, 5'd31);
		write_reg(REG_TIPS, 5'd0);
		for (int i = 0; i < 16; i++) send(1'b1, 4'(i), '0, 2'b00);
		wait_quiet();

		while (items < 1600) begin
			case ($urandom_range(0, 9))
				0: lanes_pick = 5'd1;
				1: lanes_pick = 5'd16;
				2: lanes_pick = 5'd0;
				3: lanes_pick = 5'($urandom_range(17, 31));
				default: lanes_pick = 5'($urandom_range(1, 16));
			endcase
			write_reg(REG_LANES, lanes_pick);
			write_reg(REG_TIPS, 5'($urandom_range(0, 1)));
			idle_on = ($urandom_range(0, 3) != 0);
			run_merge($urandom_range(0, 14) == 0);
			wait_quiet();
		end
		idle_on = 1'b1;
		write_reg(REG_LANES, 5'd4);
		run_merge(1'b1);
		wait_quiet();

		if (sb.mismatches == 0 && sb.pending.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
